// ----- sv/qph_pkg.sv -----
// ----------------------------------------------------------------------------
// qph_pkg
// Shared types and constants for the quadratic probe hash table: item
// layouts, command and status codes, and the controller/datapath interface.
// ----------------------------------------------------------------------------
package qph_pkg;

    // default table size and fixed field widths
    localparam int TABLE_SLOTS_DEF = 16;
    localparam int KEY_W           = 31;
    localparam int SLOT_W          = 4;

    // command codes of an input item
    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    // status codes of a result item
    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_FULL      = 3'd1,
        ST_DELETED   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FOUND     = 3'd4,
        ST_EMPTY     = 3'd5,
        ST_OCCUPIED  = 3'd6
    } t_status;

    typedef struct packed {
        t_cmd              cmd;
        logic [KEY_W-1:0]  key;
        logic [SLOT_W-1:0] slot_index;
    } t_in_item;

    typedef struct packed {
        t_status           status;
        logic [SLOT_W-1:0] slot;
        logic [KEY_W-1:0]  slot_key;
    } t_out_item;

    // one table entry as held in the slot memory
    typedef struct packed {
        logic             used;
        logic             tomb;
        logic [KEY_W-1:0] key;
    } t_slot_word;

    localparam int SLOT_WORD_W = $bits(t_slot_word);

    // controller to datapath
    typedef struct packed {
        logic    load;
        logic    mod_step;
        logic    probe_init;
        logic    probe_next;
        logic    clr_wr;
        logic    ins_wr;
        logic    del_wr;
        logic    addr_idx;
        logic    out_load;
        t_status out_status;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        t_cmd cmd;
        logic mod_done;
        logic clear_last;
        logic probe_last;
        logic used;
        logic tomb;
        logic key_match;
        logic idx_ok;
        logic out_free;
    } t_dp_stat;

endpackage

// ----- sv/qph_ram.sv -----
// ----------------------------------------------------------------------------
// qph_ram
// Generic single-port RAM with one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module qph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/qph_ctrl.sv -----
// ----------------------------------------------------------------------------
// qph_ctrl
// Controller: sequences the clearing pass, key reduction, probe loop and
// slot reads, and decides each result status.
// ----------------------------------------------------------------------------
module qph_ctrl import qph_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_cmd     i_in_cmd,
    output logic     o_in_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_MOD   = 7'b0000100,
        S_PRD   = 7'b0001000,
        S_PCHK  = 7'b0010000,
        S_RRD   = 7'b0100000,
        S_RCHK  = 7'b1000000
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_dp_cmd c;
    logic    live_match;
    logic    slot_free;

    assign live_match = i_stat.used && !i_stat.tomb && i_stat.key_match;
    assign slot_free  = !i_stat.used || i_stat.tomb;

    // next state and datapath commands
    always_comb begin
        n_state      = r_state;
        c            = '0;
        c.out_status = ST_NOT_FOUND;
        unique case (r_state)
            S_CLEAR: begin
                c.clr_wr = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    c.load  = 1'b1;
                    n_state = (i_in_cmd == CMD_READ) ? S_RRD : S_MOD;
                end
            end
            S_MOD: begin
                if (!i_stat.mod_done) begin
                    c.mod_step = 1'b1;
                end else begin
                    c.probe_init = 1'b1;
                    n_state      = S_PRD;
                end
            end
            S_PRD: begin
                n_state = S_PCHK;
            end
            S_PCHK: begin
                if (i_stat.cmd == CMD_INSERT) begin
                    if (slot_free) begin
                        if (i_stat.out_free) begin
                            c.ins_wr     = 1'b1;
                            c.out_load   = 1'b1;
                            c.out_status = ST_INSERTED;
                            n_state      = S_IDLE;
                        end
                    end else if (i_stat.probe_last) begin
                        if (i_stat.out_free) begin
                            c.out_load   = 1'b1;
                            c.out_status = ST_FULL;
                            n_state      = S_IDLE;
                        end
                    end else begin
                        c.probe_next = 1'b1;
                        n_state      = S_PRD;
                    end
                end else begin
                    if (live_match) begin
                        if (i_stat.out_free) begin
                            c.out_load   = 1'b1;
                            c.del_wr     = (i_stat.cmd == CMD_DELETE);
                            c.out_status = (i_stat.cmd == CMD_DELETE) ? ST_DELETED
                                                                      : ST_FOUND;
                            n_state      = S_IDLE;
                        end
                    end else if (!i_stat.used || i_stat.probe_last) begin
                        if (i_stat.out_free) begin
                            c.out_load   = 1'b1;
                            c.out_status = ST_NOT_FOUND;
                            n_state      = S_IDLE;
                        end
                    end else begin
                        c.probe_next = 1'b1;
                        n_state      = S_PRD;
                    end
                end
            end
            S_RRD: begin
                c.addr_idx = 1'b1;
                n_state    = S_RCHK;
            end
            S_RCHK: begin
                c.addr_idx = 1'b1;
                if (i_stat.out_free) begin
                    c.out_load   = 1'b1;
                    c.out_status = (i_stat.idx_ok && i_stat.used && !i_stat.tomb)
                                   ? ST_OCCUPIED : ST_EMPTY;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd      = c;
    assign o_in_stall = (r_state != S_IDLE);

    // a probe that passes a free slot never moves on during an insert
    a_ins_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PCHK && i_stat.cmd == CMD_INSERT && slot_free)
            |-> !c.probe_next)
        else $error("insert probed past a free slot");

    // the clearing pass ends in idle
    a_clear_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR && i_stat.clear_last) |=> (r_state == S_IDLE))
        else $error("clearing pass did not end in idle");

endmodule

// ----- sv/qph_dp.sv -----
// ----------------------------------------------------------------------------
// qph_dp
// Datapath: item registers, key reduction by reciprocal multiplication,
// incremental quadratic probe address, slot memory and result register.
// ----------------------------------------------------------------------------
module qph_dp import qph_pkg::*; #(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
    localparam int AW         = $clog2(TABLE_SLOTS),
    localparam int IW         = (AW > SLOT_W) ? AW : SLOT_W,
    localparam int SH         = KEY_W + AW
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in_item,
    input  logic      i_out_stall,
    output logic      o_out_valid,
    output t_out_item o_out_item,
    input  t_dp_cmd   i_cmd,
    output t_dp_stat  o_stat
);

    localparam logic [AW:0]   N_W  = TABLE_SLOTS[AW:0];
    localparam logic [IW:0]   N_I  = TABLE_SLOTS[IW:0];
    localparam logic [AW-1:0] N_LO = TABLE_SLOTS[AW-1:0];
    localparam logic [AW-1:0] LAST = TABLE_SLOTS[AW-1:0] - 1'b1;
    localparam logic [AW:0]   TWO  = (AW + 1)'(2);

    // rounded-up reciprocal of the size, exact quotient for every key
    localparam logic [63:0]      RECIP_W   = ((64'd1 << SH) + 64'(TABLE_SLOTS) - 64'd1)
                                             / 64'(TABLE_SLOTS);
    localparam logic [KEY_W:0]   RECIP     = RECIP_W[KEY_W:0];
    localparam logic [1:0]       MOD_STEPS = 2'd2;

    // item registers
    logic [KEY_W-1:0]  r_key;
    t_cmd              r_cmd;
    logic [SLOT_W-1:0] r_idx;
    logic [1:0]        r_mod_cnt;
    logic [2*KEY_W:0]  r_prod;
    logic [AW-1:0]     r_rem;
    logic [AW-1:0]     r_slot;
    logic [AW-1:0]     r_odd;
    logic [AW-1:0]     r_i;
    logic [AW-1:0]     r_clr_addr;
    logic              r_out_valid;
    t_out_item         r_out;

    logic [AW-1:0]     quo_lo;
    logic [2*AW-1:0]   quo_n;
    logic [AW-1:0]     rem_lo;
    logic [AW:0]       slot_t;
    logic [AW:0]       slot_s;
    logic [AW:0]       odd_t;
    logic [AW:0]       odd_s;
    logic [IW-1:0]     idx_ext;
    logic [IW-1:0]     slot_ext;
    logic              out_free;

    logic [AW-1:0]     ram_addr;
    logic              ram_we;
    t_slot_word        ram_wdata;
    t_slot_word        ram_rdata;

    // remainder: key minus quotient times size, only the low bits matter
    assign quo_lo = r_prod[SH +: AW];
    assign quo_n  = {{AW{1'b0}}, quo_lo} * {{AW{1'b0}}, N_LO};
    assign rem_lo = r_key[AW-1:0] - quo_n[AW-1:0];

    // next probe: slot += odd, odd += 2, both modulo the size
    assign slot_t = {1'b0, r_slot} + {1'b0, r_odd};
    assign slot_s = (slot_t >= N_W) ? (slot_t - N_W) : slot_t;
    assign odd_t  = {1'b0, r_odd} + TWO;
    assign odd_s  = (odd_t >= N_W) ? (odd_t - N_W) : odd_t;

    assign idx_ext  = IW'(r_idx);
    assign slot_ext = IW'(r_slot);
    assign out_free = !r_out_valid || !i_out_stall;

    // item and probe registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key     <= i_in_item.key;
            r_cmd     <= i_in_item.cmd;
            r_idx     <= i_in_item.slot_index;
            r_mod_cnt <= '0;
        end else if (i_cmd.mod_step) begin
            // first step forms the product, second takes the remainder from it
            r_prod    <= {{(KEY_W+1){1'b0}}, r_key} * {{KEY_W{1'b0}}, RECIP};
            r_rem     <= rem_lo;
            r_mod_cnt <= r_mod_cnt + 1'b1;
        end
        if (i_cmd.probe_init) begin
            r_slot <= r_rem;
            r_odd  <= AW'(1);
            r_i    <= '0;
        end else if (i_cmd.probe_next) begin
            r_slot <= slot_s[AW-1:0];
            r_odd  <= odd_s[AW-1:0];
            r_i    <= r_i + 1'b1;
        end
    end

    // clearing pass address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // slot memory port
    always_comb begin
        ram_we    = i_cmd.clr_wr || i_cmd.ins_wr || i_cmd.del_wr;
        ram_wdata = '0;
        if (i_cmd.clr_wr) begin
            ram_addr = r_clr_addr;
        end else if (i_cmd.addr_idx) begin
            ram_addr = idx_ext[AW-1:0];
        end else begin
            ram_addr = r_slot;
        end
        if (i_cmd.ins_wr || i_cmd.del_wr) begin
            ram_wdata.used = 1'b1;
            ram_wdata.tomb = i_cmd.del_wr;
            ram_wdata.key  = r_key;
        end
    end

    qph_ram #(
        .WIDTH (SLOT_WORD_W),
        .DEPTH (TABLE_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.status   <= i_cmd.out_status;
            r_out.slot_key <= '0;
            unique case (i_cmd.out_status)
                ST_INSERTED, ST_DELETED, ST_FOUND: begin
                    r_out.slot <= slot_ext[SLOT_W-1:0];
                end
                ST_EMPTY: begin
                    r_out.slot <= r_idx;
                end
                ST_OCCUPIED: begin
                    r_out.slot     <= r_idx;
                    r_out.slot_key <= ram_rdata.key;
                end
                default: begin
                    r_out.slot <= '0;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // status back to the controller
    assign o_stat.cmd        = r_cmd;
    assign o_stat.mod_done   = (r_mod_cnt == MOD_STEPS);
    assign o_stat.clear_last = (r_clr_addr == LAST);
    assign o_stat.probe_last = (r_i == LAST);
    assign o_stat.used       = ram_rdata.used;
    assign o_stat.tomb       = ram_rdata.tomb;
    assign o_stat.key_match  = (ram_rdata.key == r_key);
    assign o_stat.idx_ok     = ((IW + 1)'(r_idx) < N_I);
    assign o_stat.out_free   = out_free;

    // a new result never overwrites one still waiting
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> out_free)
        else $error("result register overwritten");

    // insert only fills a never-used or deleted slot
    a_ins_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ins_wr |-> (!ram_rdata.used || ram_rdata.tomb))
        else $error("insert into a live slot");

    // delete only marks a live slot holding the key
    a_del_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.del_wr |-> (ram_rdata.used && !ram_rdata.tomb && ram_rdata.key == r_key))
        else $error("delete of a slot not holding the key");

endmodule

// ----- sv/quadratic_probe_hash_table.sv -----
// Sequence: a slot read reads the addressed slot, then loads its result; insert, delete
//   and search reduce the key modulo the size by reciprocal multiplication (product, then
//   remainder), start the probe, then run P probes (1 to TABLE_SLOTS), each a memory read and check.
// Items: one at a time, the next taken in the cycle after the result is loaded; a result
//   still held by the far side delays the next one.
// Reset: a clearing pass writes every slot of the slot memory empty, with stall high.
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table
// Open-addressed hash table with quadratic probing and tombstones: insert,
// delete, search and single-slot read.
// ----------------------------------------------------------------------------
module quadratic_probe_hash_table import qph_pkg::*; #(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // sequencing
    qph_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_cmd   (i_in_item.cmd),
        .o_in_stall (o_in_stall),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    // storage and arithmetic
    qph_dp #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat)
    );

endmodule

// ----- tb/sv/qph_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qph_checker
// Watches both item channels of the hash table, keeps its own copy of the
// slot table to work out each result, and compares every result item with
// the oldest expected one, field by field.
// ----------------------------------------------------------------------------
module qph_checker import qph_pkg::*; #(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  t_in_item   i_in_item,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  t_out_item  i_out_item,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_checked,
    output logic [7:0] o_status_seen
);

    // shadow copy of the slot table
    logic [KEY_W-1:0] table_keys [TABLE_SLOTS];
    bit               table_used [TABLE_SLOTS];
    bit               table_tomb [TABLE_SLOTS];

    t_out_item  expected_results [$];
    int         fail_count  = 0;
    int         pending     = 0;
    int         checked     = 0;
    logic [7:0] status_seen = '0;

    assign o_fail_count  = fail_count;
    assign o_pending     = pending;
    assign o_checked     = checked;
    assign o_status_seen = status_seen;

    // slot visited by probe n of a key
    function automatic int probe_slot(input logic [KEY_W-1:0] key, input int n);
        int home;
        home = int'(longint'(key) % TABLE_SLOTS);
        return (home + (n * n) % TABLE_SLOTS) % TABLE_SLOTS;
    endfunction

    // first live slot holding the key, -1 when absent; stops at a never-used slot
    function automatic int find_live_slot(input logic [KEY_W-1:0] key);
        int  n;
        int  s;
        int  hit;
        bit  stop;
        hit  = -1;
        stop = 1'b0;
        for (n = 0; n < TABLE_SLOTS && !stop; n++) begin
            s = probe_slot(key, n);
            if (table_used[s] && !table_tomb[s] && table_keys[s] == key) begin
                hit  = s;
                stop = 1'b1;
            end else if (!table_used[s]) begin
                stop = 1'b1;
            end
        end
        return hit;
    endfunction

    // apply one command to the shadow table and give the result it should produce
    function automatic t_out_item apply_table_op(input t_in_item it);
        t_out_item r;
        int        n;
        int        s;
        bit        placed;
        r.status   = ST_NOT_FOUND;
        r.slot     = '0;
        r.slot_key = '0;
        case (it.cmd)
            CMD_INSERT: begin
                r.status = ST_FULL;
                placed   = 1'b0;
                for (n = 0; n < TABLE_SLOTS && !placed; n++) begin
                    s = probe_slot(it.key, n);
                    if (!table_used[s] || table_tomb[s]) begin
                        table_keys[s] = it.key;
                        table_used[s] = 1'b1;
                        table_tomb[s] = 1'b0;
                        r.status      = ST_INSERTED;
                        r.slot        = SLOT_W'(s);
                        placed        = 1'b1;
                    end
                end
            end
            CMD_DELETE, CMD_SEARCH: begin
                s = find_live_slot(it.key);
                if (s >= 0) begin
                    r.slot = SLOT_W'(s);
                    if (it.cmd == CMD_DELETE) begin
                        table_tomb[s] = 1'b1;
                        r.status      = ST_DELETED;
                    end else begin
                        r.status = ST_FOUND;
                    end
                end
            end
            default: begin
                r.slot   = it.slot_index;
                r.status = ST_EMPTY;
                s        = int'(it.slot_index);
                if (s < TABLE_SLOTS) begin
                    if (table_used[s] && !table_tomb[s]) begin
                        r.status   = ST_OCCUPIED;
                        r.slot_key = table_keys[s];
                    end
                end
            end
        endcase
        return r;
    endfunction

    // compare results first, then predict for an accepted item
    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        if (!i_rst_n) begin
            for (int n = 0; n < TABLE_SLOTS; n++) begin
                table_used[n] = 1'b0;
                table_tomb[n] = 1'b0;
            end
            expected_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = i_out_item;
                if (expected_results.size() == 0) begin
                    $error("result item with nothing expected: status %0d slot %0d key %0h",
                           got.status, got.slot, got.slot_key);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    checked++;
                    status_seen[got.status] = 1'b1;
                    if (got.status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, got.status);
                        fail_count++;
                    end
                    if (got.slot !== want.slot) begin
                        $error("slot mismatch: expected %0d, actual %0d",
                               want.slot, got.slot);
                        fail_count++;
                    end
                    if (got.slot_key !== want.slot_key) begin
                        $error("slot_key mismatch: expected %0h, actual %0h",
                               want.slot_key, got.slot_key);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_results.push_back(apply_table_op(i_in_item));
            end
        end
        pending = expected_results.size();
    end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives insert, delete, search and slot read commands into the hash table:
// a directed opening on collisions, duplicates, tombstones and a full probe
// chain, then random phases with bursty input and a varying output stall.
// ----------------------------------------------------------------------------
module testbench import qph_pkg::*; ();

    localparam int RESET_CYCLES    = 6;
    localparam int RANDOM_ITEMS    = 1500;
    localparam int PHASES          = 6;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 100;
    localparam int POOL_DEPTH      = 40;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_item;

    int         fail_count;
    int         pending;
    int         checked;
    logic [7:0] status_seen;

    int               items_sent    = 0;
    int               burst_left    = 1;
    int               hold_requests = 0;
    int               holds_served  = 0;
    int               stall_mode    = 0;
    int               stall_left    = 0;
    logic [KEY_W-1:0] key_pool [$];

    quadratic_probe_hash_table dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    qph_checker chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_in_item     (i_in_item),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_out_item    (o_out_item),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_status_seen (status_seen)
    );

    // 8 ns clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #6_000_000;
        $display("tb: failure");
        $finish;
    end

    // receiver stall: random patterns, plus a long hold-off on request
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_requests != holds_served) begin
                holds_served = hold_requests;
                i_out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
            end
            if (stall_left == 0) begin
                stall_mode = $urandom_range(2, 0);
                stall_left = $urandom_range(200, 10);
            end
            stall_left--;
            case (stall_mode)
                0:       i_out_stall <= 1'b0;
                1:       i_out_stall <= ($urandom_range(3, 0) == 0);
                default: i_out_stall <= ($urandom_range(3, 0) != 0);
            endcase
        end
    end

    // offer one item and hold it until taken; gaps come between bursts
    task automatic push_item(input t_in_item it);
        int gap;
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall) break;
        end
        @(negedge i_clk);
        items_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(4, 0) == 0) ? $urandom_range(60, 20)
                                                     : $urandom_range(12, 1);
            gap = ($urandom_range(3, 0) == 0) ? $urandom_range(80, 1)
                                              : $urandom_range(6, 0);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    task automatic send_op(input t_cmd c, input logic [KEY_W-1:0] k,
                           input logic [SLOT_W-1:0] idx);
        t_in_item it;
        it.cmd        = c;
        it.key        = k;
        it.slot_index = idx;
        push_item(it);
    endtask

    // stop offering until every expected result has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        burst_left = 1;
        while (pending != 0) @(negedge i_clk);
    endtask

    // random key whose home slot lies in the lowest span slots
    function automatic logic [KEY_W-1:0] fresh_key(input int span);
        logic [KEY_W-1:0] k;
        k = KEY_W'($urandom);
        k[SLOT_W-1:0] = SLOT_W'($urandom_range(span - 1, 0));
        return k;
    endfunction

    function automatic logic [KEY_W-1:0] pool_key();
        return key_pool[$urandom_range(key_pool.size() - 1, 0)];
    endfunction

    // one random phase; weights in percent, reads take what is left
    task automatic run_phase(input int n, input int w_ins, input int w_del,
                             input int w_srch, input int span);
        t_in_item it;
        int       roll;
        repeat (n) begin
            roll          = $urandom_range(99, 0);
            it.slot_index = SLOT_W'($urandom);
            it.key        = fresh_key(span);
            if (roll < w_ins) begin
                it.cmd = CMD_INSERT;
                // some duplicates of keys already in play
                if (key_pool.size() > 0 && $urandom_range(4, 0) == 0)
                    it.key = pool_key();
                key_pool.push_back(it.key);
                if (key_pool.size() > POOL_DEPTH) void'(key_pool.pop_front());
            end else if (roll < w_ins + w_del + w_srch) begin
                it.cmd = (roll < w_ins + w_del) ? CMD_DELETE : CMD_SEARCH;
                if (key_pool.size() > 0 && $urandom_range(3, 0) != 0)
                    it.key = pool_key();
            end else begin
                it.cmd = CMD_READ;
            end
            push_item(it);
        end
    endtask

    // stimulus and verdict
    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_item  = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty table: reads of both end slots, lookups that miss
        send_op(CMD_READ,   '0, 4'd0);
        send_op(CMD_READ,   '0, 4'd15);
        send_op(CMD_SEARCH, '0, 4'd0);
        send_op(CMD_DELETE, 31'd5, 4'd15);
        // extreme keys, then read them back
        send_op(CMD_INSERT, '0, 4'd0);
        send_op(CMD_INSERT, 31'h7FFF_FFFF, 4'd0);
        send_op(CMD_READ,   '0, 4'd0);
        send_op(CMD_READ,   '0, 4'd15);
        // duplicate and collisions on home slot 0 until its chain is full
        send_op(CMD_INSERT, '0, 4'd0);
        send_op(CMD_INSERT, 31'd16, 4'd0);
        send_op(CMD_INSERT, 31'd32, 4'd0);
        send_op(CMD_INSERT, 31'd48, 4'd0);
        // tombstone: deleted slot reads empty, the duplicate is still found
        send_op(CMD_SEARCH, '0, 4'd0);
        send_op(CMD_DELETE, '0, 4'd0);
        send_op(CMD_READ,   '0, 4'd0);
        send_op(CMD_SEARCH, '0, 4'd0);
        // miss after a full-length probe run, then reuse of the tombstone
        send_op(CMD_SEARCH, 31'd64, 4'd0);
        send_op(CMD_DELETE, 31'd48, 4'd0);
        send_op(CMD_INSERT, 31'd48, 4'd0);
        send_op(CMD_READ,   '0, 4'd0);
        // delete the largest key, then a search that stops at an unused slot
        send_op(CMD_DELETE, 31'h7FFF_FFFF, 4'd15);
        send_op(CMD_SEARCH, 31'h7FFF_FFFF, 4'd15);
        send_op(CMD_READ,   '0, 4'd15);
        wait_drained();

        // random phases with different mixes and collision spreads
        for (int ph = 0; ph < PHASES; ph++) begin
            // long output hold-off while items keep coming
            if (ph == 1) hold_requests <= hold_requests + 1;
            case (ph)
                0:       run_phase(RANDOM_ITEMS / PHASES, 60, 10, 15, 4);
                1:       run_phase(RANDOM_ITEMS / PHASES, 25, 35, 25, 4);
                2:       run_phase(RANDOM_ITEMS / PHASES, 40, 20, 30, 16);
                3:       run_phase(RANDOM_ITEMS / PHASES, 30, 30, 30, 2);
                4:       run_phase(RANDOM_ITEMS / PHASES, 25, 25, 25, 16);
                default: run_phase(RANDOM_ITEMS / PHASES, 50, 30, 15, 8);
            endcase
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(negedge i_clk);
        $display("summary: %0d items sent, %0d results checked, status codes seen %b",
                 items_sent, checked, status_seen[6:0]);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
